>>> hw/rtl/ect_pkg.sv
package ect_pkg;

   localparam int COORD_W = 10;
   localparam int STAMP_W = 32;
   localparam int FRAC_W  = 8;
   localparam int MEAN_W  = COORD_W + FRAC_W;
   localparam int DIST_W  = MEAN_W + 1;
   localparam int MIND_W  = COORD_W + 1;
   localparam int BW_W    = 9;
   localparam int ACC_W   = BW_W + MEAN_W;
   localparam int ACT_W   = 2;
   localparam int DATA_W  = 32;
   localparam int ADDR_W  = 3;

   localparam logic [ACT_W-1:0] ACT_ADD     = 2'd0;
   localparam logic [ACT_W-1:0] ACT_FORGET  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_MEASURE = 2'd2;

   localparam logic REG_BLEND  = 1'b0;
   localparam logic REG_ORIGIN = 1'b1;

   localparam logic [MIND_W-1:0] EMPTY_DIST  = 11'd2047;
   localparam logic [BW_W-1:0]   W_ONE       = 9'd256;
   localparam logic [BW_W-1:0]   BLEND_RESET = 9'd205;

   typedef logic [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type          x;
      coord_type          y;
      logic [STAMP_W-1:0] t;
   } event_type;

endpackage

>>> hw/rtl/event_cluster_tracker_top.sv
// Tracks one cluster of camera events held in a DEPTH-entry circular store. An item is
// accepted in the idle cycle and the input is not ready while it is in work. An add
// stores the event and then blends the Q10.8 mean on the shared 9x18 multiplier
// (skipped for the first event or a full store); a forget checks the head entries in
// turn, popping each one stamped before the item, until a kept entry or an empty store
// stops it. Every item then starts the scan, a scan of all held events through the
// single store read port overlapped with the centroid divider (the scan waits for it),
// and loads the result register. A finished result waits in an output register while
// the next item is accepted.
module event_cluster_tracker_top #(
   parameter int DEPTH = 64
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ect_pkg::ACT_W-1:0]     req_action,
   input  logic [ect_pkg::COORD_W-1:0]   req_pos_x,
   input  logic [ect_pkg::COORD_W-1:0]   req_pos_y,
   input  logic signed [ect_pkg::STAMP_W-1:0] req_stamp,

   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [$clog2(DEPTH+1)-1:0]    rsp_count,
   output logic [ect_pkg::MEAN_W-1:0]    rsp_mean_x,
   output logic [ect_pkg::MEAN_W-1:0]    rsp_mean_y,
   output logic [ect_pkg::DIST_W-1:0]    rsp_dist_mean,
   output logic [ect_pkg::MIND_W-1:0]    rsp_min_dist,
   output logic [ect_pkg::COORD_W-1:0]   rsp_centroid_x,
   output logic [ect_pkg::COORD_W-1:0]   rsp_centroid_y,
   output logic                          rsp_empty_res,
   output logic                          rsp_rejected,

   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [ect_pkg::ADDR_W-1:0]    paddr,
   input  logic [ect_pkg::DATA_W-1:0]    pwdata,
   output logic [ect_pkg::DATA_W-1:0]    prdata,
   output logic                          pready
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = ect_pkg::COORD_W + CNT_W;
   localparam int COORD_W = ect_pkg::COORD_W;
   localparam int MEAN_W = ect_pkg::MEAN_W;
   localparam int ACC_W = ect_pkg::ACC_W;
   localparam int BW_W = ect_pkg::BW_W;
   localparam int STAMP_W = ect_pkg::STAMP_W;
   localparam int MIND_W = ect_pkg::MIND_W;

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_ADD       = 3'd1;
   localparam logic [2:0] S_MUL       = 3'd2;
   localparam logic [2:0] S_FGT_RD    = 3'd3;
   localparam logic [2:0] S_FGT_CHK   = 3'd4;
   localparam logic [2:0] S_SCAN_INIT = 3'd5;
   localparam logic [2:0] S_SCAN      = 3'd6;
   localparam logic [2:0] S_DONE      = 3'd7;

   localparam logic [2:0] MSTEP_LAST = 3'd4;

   // configuration
   logic [BW_W-1:0]    blend_ff, blend_in;
   logic [STAMP_W-1:0] origin_ff, origin_in;
   logic               csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite;

   always_comb begin
      blend_in  = blend_ff;
      origin_in = origin_ff;
      if (csr_wr) begin
         if (paddr[2] == ect_pkg::REG_ORIGIN) begin
            origin_in = pwdata;
         end else begin
            blend_in = pwdata[BW_W-1:0];
         end
      end
      if (paddr[2] == ect_pkg::REG_ORIGIN) begin
         prdata = origin_ff;
      end else begin
         prdata = {{(ect_pkg::DATA_W-BW_W){1'b0}}, blend_ff};
      end
   end

   // cluster state
   logic [2:0]          state_ff, state_in;
   logic [IDX_W-1:0]    head_ff, head_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [MEAN_W-1:0]   mean_x_ff, mean_x_in, mean_y_ff, mean_y_in;
   logic [SUM_W-1:0]    sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;

   // item under work
   logic [ect_pkg::ACT_W-1:0] act_ff, act_in;
   logic [COORD_W-1:0]  px_ff, px_in, py_ff, py_in;
   logic [STAMP_W-1:0]  stamp_ff, stamp_in;
   logic                rej_ff, rej_in;
   logic [2:0]          mstep_ff, mstep_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [IDX_W-1:0]    ptr_ff, ptr_in;
   logic [CNT_W-1:0]    left_ff, left_in;
   logic                rdv_ff, rdv_in;
   logic [MIND_W-1:0]   best_ff, best_in;

   // result register
   logic                out_valid_ff, out_valid_in;
   logic [CNT_W-1:0]    o_count_ff;
   logic [MEAN_W-1:0]   o_mean_x_ff, o_mean_y_ff;
   logic [ect_pkg::DIST_W-1:0] o_dist_ff;
   logic [MIND_W-1:0]   o_min_ff;
   logic [COORD_W-1:0]  o_cx_ff, o_cy_ff;
   logic                o_empty_ff, o_rej_ff;
   logic                load_out;

   // store
   ect_pkg::event_type  mem [DEPTH];
   ect_pkg::event_type  rd_data_ff, wr_data;
   logic [IDX_W-1:0]    rd_addr, wr_addr;
   logic                wr_en;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
      idx_inc = (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [COORD_W-1:0] coord_diff(input logic [COORD_W-1:0] a,
                                                     input logic [COORD_W-1:0] b);
      coord_diff = (a > b) ? a - b : b - a;
   endfunction

   function automatic logic [MEAN_W-1:0] mean_diff(input logic [MEAN_W-1:0] a,
                                                   input logic [MEAN_W-1:0] b);
      mean_diff = (a > b) ? a - b : b - a;
   endfunction

   // shared multiplier for the mean blend
   logic [BW_W-1:0]   w_eff, w_inv, mul_a;
   logic [MEAN_W-1:0] mul_b;
   logic [ACC_W-1:0]  prod;

   assign w_eff = (blend_ff > ect_pkg::W_ONE) ? ect_pkg::W_ONE : blend_ff;
   assign w_inv = ect_pkg::W_ONE - w_eff;

   always_comb begin
      mul_a = mstep_ff[0] ? w_eff : w_inv;
      case (mstep_ff[1:0])
         2'd0:    mul_b = mean_x_ff;
         2'd1:    mul_b = {px_ff, {ect_pkg::FRAC_W{1'b0}}};
         2'd2:    mul_b = mean_y_ff;
         default: mul_b = {py_ff, {ect_pkg::FRAC_W{1'b0}}};
      endcase
      prod = mul_a * mul_b;
   end

   // centroid divider
   logic               div_start, div_busy;
   ect_pkg::coord_type quot_x, quot_y;

   ect_div #(
      .CNT_W (CNT_W),
      .SUM_W (SUM_W)
   ) u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num_x  (sum_x_ff),
      .num_y  (sum_y_ff),
      .den    (count_ff),
      .busy   (div_busy),
      .quot_x (quot_x),
      .quot_y (quot_y)
   );

   logic [CNT_W:0]      slot_sum, slot_wrap;
   logic [MIND_W-1:0]   scan_dist;
   logic                pop;

   always_comb begin
      slot_sum  = (CNT_W+1)'(head_ff) + (CNT_W+1)'(count_ff);
      slot_wrap = (slot_sum >= (CNT_W+1)'(DEPTH)) ? slot_sum - (CNT_W+1)'(DEPTH) : slot_sum;
      scan_dist = MIND_W'(coord_diff(px_ff, rd_data_ff.x))
                + MIND_W'(coord_diff(py_ff, rd_data_ff.y));
      pop       = $signed(rd_data_ff.t) < $signed(stamp_ff);
   end

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      mean_x_in = mean_x_ff;
      mean_y_in = mean_y_ff;
      sum_x_in  = sum_x_ff;
      sum_y_in  = sum_y_ff;
      act_in    = act_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      stamp_in  = stamp_ff;
      rej_in    = rej_ff;
      mstep_in  = mstep_ff;
      acc_in    = acc_ff;
      ptr_in    = ptr_ff;
      left_in   = left_ff;
      rdv_in    = 1'b0;
      best_in   = best_ff;
      rd_addr   = ptr_ff;
      wr_addr   = slot_wrap[IDX_W-1:0];
      wr_data.x = px_ff;
      wr_data.y = py_ff;
      wr_data.t = stamp_ff - origin_ff;
      wr_en     = 1'b0;
      div_start = 1'b0;
      load_out  = 1'b0;
      req_ready = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               act_in   = req_action;
               px_in    = req_pos_x;
               py_in    = req_pos_y;
               stamp_in = req_stamp;
               rej_in   = 1'b0;
               unique case (req_action)
                  ect_pkg::ACT_ADD:    state_in = S_ADD;
                  ect_pkg::ACT_FORGET: state_in = S_FGT_RD;
                  default:             state_in = S_SCAN_INIT;
               endcase
            end
         end
         S_ADD: begin
            if (count_ff == CNT_W'(DEPTH)) begin
               rej_in   = 1'b1;
               state_in = S_SCAN_INIT;
            end else begin
               wr_en    = 1'b1;
               sum_x_in = sum_x_ff + SUM_W'(px_ff);
               sum_y_in = sum_y_ff + SUM_W'(py_ff);
               count_in = count_ff + 1'b1;
               if (count_ff == '0) begin
                  mean_x_in = {px_ff, {ect_pkg::FRAC_W{1'b0}}};
                  mean_y_in = {py_ff, {ect_pkg::FRAC_W{1'b0}}};
                  state_in  = S_SCAN_INIT;
               end else begin
                  mstep_in = '0;
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            // even steps start a product, odd steps accumulate, step 2 and 4 retire
            acc_in   = (mstep_ff[0] ? acc_ff : '0) + prod;
            mstep_in = mstep_ff + 1'b1;
            if (mstep_ff == 3'd2) begin
               mean_x_in = acc_ff[ACC_W-2:ect_pkg::FRAC_W];
            end
            if (mstep_ff == MSTEP_LAST) begin
               mean_y_in = acc_ff[ACC_W-2:ect_pkg::FRAC_W];
               state_in  = S_SCAN_INIT;
            end
         end
         S_FGT_RD: begin
            rd_addr = head_ff;
            if (count_ff == '0) begin
               state_in = S_SCAN_INIT;
            end else begin
               state_in = S_FGT_CHK;
            end
         end
         S_FGT_CHK: begin
            // read of the next head entry goes out while this one pops
            rd_addr = idx_inc(head_ff);
            if (pop) begin
               head_in  = idx_inc(head_ff);
               count_in = count_ff - 1'b1;
               sum_x_in = sum_x_ff - SUM_W'(rd_data_ff.x);
               sum_y_in = sum_y_ff - SUM_W'(rd_data_ff.y);
               if (count_ff == CNT_W'(1)) begin
                  state_in = S_SCAN_INIT;
               end
            end else begin
               state_in = S_SCAN_INIT;
            end
         end
         S_SCAN_INIT: begin
            ptr_in    = head_ff;
            left_in   = count_ff;
            best_in   = ect_pkg::EMPTY_DIST;
            div_start = 1'b1;
            state_in  = S_SCAN;
         end
         S_SCAN: begin
            rd_addr = ptr_ff;
            if (left_ff != '0) begin
               rdv_in  = 1'b1;
               ptr_in  = idx_inc(ptr_ff);
               left_in = left_ff - 1'b1;
            end
            if (rdv_ff && (scan_dist < best_ff)) begin
               best_in = scan_dist;
            end
            if ((left_ff == '0) && !rdv_ff && !div_busy) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!out_valid_ff || rsp_ready) begin
               load_out = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (load_out) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         mean_x_ff    <= '0;
         mean_y_ff    <= '0;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         rdv_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
         blend_ff     <= ect_pkg::BLEND_RESET;
         origin_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         mean_x_ff    <= mean_x_in;
         mean_y_ff    <= mean_y_in;
         sum_x_ff     <= sum_x_in;
         sum_y_ff     <= sum_y_in;
         rdv_ff       <= rdv_in;
         out_valid_ff <= out_valid_in;
         blend_ff     <= blend_in;
         origin_ff    <= origin_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff   <= act_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      stamp_ff <= stamp_in;
      rej_ff   <= rej_in;
      mstep_ff <= mstep_in;
      acc_ff   <= acc_in;
      ptr_ff   <= ptr_in;
      left_ff  <= left_in;
      best_ff  <= best_in;
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         o_count_ff  <= count_ff;
         o_mean_x_ff <= mean_x_ff;
         o_mean_y_ff <= mean_y_ff;
         o_dist_ff   <= ect_pkg::DIST_W'(mean_diff({px_ff, {ect_pkg::FRAC_W{1'b0}}}, mean_x_ff))
                      + ect_pkg::DIST_W'(mean_diff({py_ff, {ect_pkg::FRAC_W{1'b0}}}, mean_y_ff));
         o_min_ff    <= best_ff;
         o_cx_ff     <= (count_ff == '0) ? '0 : quot_x;
         o_cy_ff     <= (count_ff == '0) ? '0 : quot_y;
         o_empty_ff  <= count_ff == '0;
         o_rej_ff    <= rej_ff && (act_ff == ect_pkg::ACT_ADD);
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_count      = o_count_ff;
   assign rsp_mean_x     = o_mean_x_ff;
   assign rsp_mean_y     = o_mean_y_ff;
   assign rsp_dist_mean  = o_dist_ff;
   assign rsp_min_dist   = o_min_ff;
   assign rsp_centroid_x = o_cx_ff;
   assign rsp_centroid_y = o_cy_ff;
   assign rsp_empty_res  = o_empty_ff;
   assign rsp_rejected   = o_rej_ff;

endmodule

>>> hw/rtl/ect_div.sv
module ect_div #(
   parameter int CNT_W = 7,
   parameter int SUM_W = 17
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [SUM_W-1:0]       num_x,
   input  logic [SUM_W-1:0]       num_y,
   input  logic [CNT_W-1:0]       den,
   output logic                   busy,
   output ect_pkg::coord_type     quot_x,
   output ect_pkg::coord_type     quot_y
);

   localparam int ITER_W = $clog2(SUM_W + 1);

   logic [SUM_W-1:0]  qx_ff, qx_in, qy_ff, qy_in;
   logic [CNT_W-1:0]  rx_ff, rx_in, ry_ff, ry_in;
   logic [CNT_W-1:0]  den_ff, den_in;
   logic [ITER_W-1:0] iter_ff, iter_in;

   logic [CNT_W:0] trial_x, trial_y, diff_x, diff_y;
   logic           ge_x, ge_y;

   // restoring division, one quotient bit per cycle for both coordinates
   always_comb begin
      trial_x = {rx_ff, qx_ff[SUM_W-1]};
      trial_y = {ry_ff, qy_ff[SUM_W-1]};
      ge_x    = trial_x >= {1'b0, den_ff};
      ge_y    = trial_y >= {1'b0, den_ff};
      diff_x  = trial_x - {1'b0, den_ff};
      diff_y  = trial_y - {1'b0, den_ff};

      qx_in   = qx_ff;
      qy_in   = qy_ff;
      rx_in   = rx_ff;
      ry_in   = ry_ff;
      den_in  = den_ff;
      iter_in = iter_ff;

      if (start) begin
         qx_in   = num_x;
         qy_in   = num_y;
         rx_in   = '0;
         ry_in   = '0;
         den_in  = den;
         iter_in = ITER_W'(SUM_W);
      end else if (iter_ff != '0) begin
         rx_in   = ge_x ? diff_x[CNT_W-1:0] : trial_x[CNT_W-1:0];
         ry_in   = ge_y ? diff_y[CNT_W-1:0] : trial_y[CNT_W-1:0];
         qx_in   = {qx_ff[SUM_W-2:0], ge_x};
         qy_in   = {qy_ff[SUM_W-2:0], ge_y};
         iter_in = iter_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iter_ff <= '0;
      end else begin
         iter_ff <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      qx_ff  <= qx_in;
      qy_ff  <= qy_in;
      rx_ff  <= rx_in;
      ry_ff  <= ry_in;
      den_ff <= den_in;
   end

   assign busy   = iter_ff != '0;
   assign quot_x = qx_ff[ect_pkg::COORD_W-1:0];
   assign quot_y = qy_ff[ect_pkg::COORD_W-1:0];

endmodule

>>> sim/tb_event_cluster_tracker_top.sv
`timescale 1ns / 1ps

module tb_event_cluster_tracker_top;

   localparam int DEPTH        = 64;
   localparam int IDX_W        = $clog2(DEPTH);
   localparam int CNT_W        = $clog2(DEPTH + 1);
   localparam int CYCLE_LIMIT  = 2000000;
   localparam int DRAIN_CYCLES = 100;
   localparam int HOLD_CYCLES  = 3000;
   localparam int PHASE_ITEMS  = 280;

   localparam int ACT_W   = ect_pkg::ACT_W;
   localparam int COORD_W = ect_pkg::COORD_W;
   localparam int STAMP_W = ect_pkg::STAMP_W;
   localparam int FRAC_W  = ect_pkg::FRAC_W;
   localparam int MEAN_W  = ect_pkg::MEAN_W;
   localparam int DIST_W  = ect_pkg::DIST_W;
   localparam int MIND_W  = ect_pkg::MIND_W;
   localparam int BW_W    = ect_pkg::BW_W;
   localparam int DATA_W  = ect_pkg::DATA_W;
   localparam int ADDR_W  = ect_pkg::ADDR_W;

   // action code with no meaning of its own, handled as a measure
   localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

   typedef struct packed {
      logic [CNT_W-1:0]   count;
      logic [MEAN_W-1:0]  mean_x;
      logic [MEAN_W-1:0]  mean_y;
      logic [DIST_W-1:0]  dist_mean;
      logic [MIND_W-1:0]  min_dist;
      ect_pkg::coord_type centroid_x;
      ect_pkg::coord_type centroid_y;
      logic               empty_res;
      logic               rejected;
   } cluster_rsp_type;

   class cluster_scoreboard_type;
      ect_pkg::coord_type ev_x[DEPTH];
      ect_pkg::coord_type ev_y[DEPTH];
      logic [STAMP_W-1:0] ev_t[DEPTH];
      int unsigned        head;
      int unsigned        held;
      logic [MEAN_W-1:0]  mean_col;
      logic [MEAN_W-1:0]  mean_row;
      int unsigned        sum_col;
      int unsigned        sum_row;
      logic [BW_W-1:0]    weight;
      logic [STAMP_W-1:0] origin;
      cluster_rsp_type    expected_q[$];
      int                 errors;

      function new();
         head     = 0;
         held     = 0;
         mean_col = '0;
         mean_row = '0;
         sum_col  = 0;
         sum_row  = 0;
         weight   = ect_pkg::BLEND_RESET;
         origin   = '0;
         errors   = 0;
      endfunction

      function void set_register(logic idx, logic [DATA_W-1:0] value);
         if (idx == ect_pkg::REG_BLEND) begin
            weight = value[BW_W-1:0];
         end else begin
            origin = value;
         end
      endfunction

      function logic [MEAN_W-1:0] blend(logic [MEAN_W-1:0] m, ect_pkg::coord_type pix);
         longint unsigned w;
         longint unsigned acc;
         // weights above one saturate at one
         w   = 64'((weight > ect_pkg::W_ONE) ? ect_pkg::W_ONE : weight);
         acc = (64'(ect_pkg::W_ONE) - w) * 64'(m) + w * (64'(pix) << FRAC_W);
         return MEAN_W'(acc >> FRAC_W);
      endfunction

      function int unsigned abs_diff(int unsigned a, int unsigned b);
         return (a > b) ? a - b : b - a;
      endfunction

      // update the cluster state for one accepted item and queue its result
      function void note_item(logic [ACT_W-1:0] act, ect_pkg::coord_type px,
                              ect_pkg::coord_type py, logic [STAMP_W-1:0] stamp);
         cluster_rsp_type want;
         int unsigned     slot;
         int unsigned     best;
         int unsigned     d;
         want.rejected = 1'b0;
         if (act == ect_pkg::ACT_ADD) begin
            if (held >= DEPTH) begin
               want.rejected = 1'b1;
            end else begin
               slot                = (head + held) % DEPTH;
               ev_x[IDX_W'(slot)] = px;
               ev_y[IDX_W'(slot)] = py;
               ev_t[IDX_W'(slot)] = stamp - origin;
               if (held == 0) begin
                  mean_col = {px, {FRAC_W{1'b0}}};
                  mean_row = {py, {FRAC_W{1'b0}}};
               end else begin
                  mean_col = blend(mean_col, px);
                  mean_row = blend(mean_row, py);
               end
               sum_col += 32'(px);
               sum_row += 32'(py);
               held++;
            end
         end else if (act == ect_pkg::ACT_FORGET) begin
            while (held > 0 && $signed(ev_t[IDX_W'(head)]) < $signed(stamp)) begin
               sum_col -= 32'(ev_x[IDX_W'(head)]);
               sum_row -= 32'(ev_y[IDX_W'(head)]);
               head = (head + 1) % DEPTH;
               held--;
            end
         end
         best = 32'(ect_pkg::EMPTY_DIST);
         for (int i = 0; i < held; i++) begin
            slot = (head + i) % DEPTH;
            d    = abs_diff(32'(px), 32'(ev_x[IDX_W'(slot)]))
                 + abs_diff(32'(py), 32'(ev_y[IDX_W'(slot)]));
            if (d < best) begin
               best = d;
            end
         end
         want.count      = CNT_W'(held);
         want.mean_x     = mean_col;
         want.mean_y     = mean_row;
         want.dist_mean  = DIST_W'(abs_diff(32'({px, {FRAC_W{1'b0}}}), 32'(mean_col))
                         + abs_diff(32'({py, {FRAC_W{1'b0}}}), 32'(mean_row)));
         want.min_dist   = MIND_W'(best);
         want.centroid_x = (held != 0) ? COORD_W'(sum_col / held) : '0;
         want.centroid_y = (held != 0) ? COORD_W'(sum_row / held) : '0;
         want.empty_res  = (held == 0);
         expected_q = {expected_q, want};
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(cluster_rsp_type got);
         cluster_rsp_type want;
         if (expected_q.size() == 0) begin
            $error("result transfer with no expected result waiting");
            errors++;
            return;
         end
         want = expected_q[0];
         expected_q.delete(0);
         compare_field("count", 32'(want.count), 32'(got.count));
         compare_field("mean_x", 32'(want.mean_x), 32'(got.mean_x));
         compare_field("mean_y", 32'(want.mean_y), 32'(got.mean_y));
         compare_field("dist_mean", 32'(want.dist_mean), 32'(got.dist_mean));
         compare_field("min_dist", 32'(want.min_dist), 32'(got.min_dist));
         compare_field("centroid_x", 32'(want.centroid_x), 32'(got.centroid_x));
         compare_field("centroid_y", 32'(want.centroid_y), 32'(got.centroid_y));
         compare_field("empty_res", 32'(want.empty_res), 32'(got.empty_res));
         compare_field("rejected", 32'(want.rejected), 32'(got.rejected));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;

   logic                  req_valid  = 1'b0;
   logic                  req_ready;
   logic [ACT_W-1:0]      req_action = ect_pkg::ACT_MEASURE;
   logic [COORD_W-1:0]    req_pos_x  = '0;
   logic [COORD_W-1:0]    req_pos_y  = '0;
   logic [STAMP_W-1:0]    req_stamp  = '0;

   logic                  rsp_valid;
   logic                  rsp_ready  = 1'b0;
   logic [CNT_W-1:0]      rsp_count;
   logic [MEAN_W-1:0]     rsp_mean_x;
   logic [MEAN_W-1:0]     rsp_mean_y;
   logic [DIST_W-1:0]     rsp_dist_mean;
   logic [MIND_W-1:0]     rsp_min_dist;
   logic [COORD_W-1:0]    rsp_centroid_x;
   logic [COORD_W-1:0]    rsp_centroid_y;
   logic                  rsp_empty_res;
   logic                  rsp_rejected;

   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [ADDR_W-1:0]     paddr   = '0;
   logic [DATA_W-1:0]     pwdata  = '0;
   logic [DATA_W-1:0]     prdata;
   logic                  pready;

   cluster_scoreboard_type sb = new();
   int                    cycles    = 0;
   int                    calm_left = 0;
   bit                    hold_req  = 1'b0;
   logic [STAMP_W-1:0]    rel_now   = '0;

   event_cluster_tracker_top #(.DEPTH(DEPTH)) i_dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock) begin : rsp_monitor
      cluster_rsp_type got;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         got.count      = rsp_count;
         got.mean_x     = rsp_mean_x;
         got.mean_y     = rsp_mean_y;
         got.dist_mean  = rsp_dist_mean;
         got.min_dist   = rsp_min_dist;
         got.centroid_x = rsp_centroid_x;
         got.centroid_y = rsp_centroid_y;
         got.empty_res  = rsp_empty_res;
         got.rejected   = rsp_rejected;
         sb.check_result(got);
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin : rsp_side
      int r;
      forever begin
         if (hold_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req = 1'b0;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
               rsp_ready <= 1'b1;
               repeat ($urandom_range(1, 40)) @(posedge clock);
            end else if (r < 92) begin
               rsp_ready <= 1'b0;
               repeat ($urandom_range(1, 4)) @(posedge clock);
            end else begin
               rsp_ready <= 1'b0;
               repeat ($urandom_range(10, 60)) @(posedge clock);
            end
         end
      end
   end

   function automatic int sender_gap();
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm_left = $urandom_range(20, 60);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 4);
      return $urandom_range(10, 40);
   endfunction

   function automatic ect_pkg::coord_type near_coord(int c);
      int v;
      int r;
      r = $urandom_range(0, 15);
      if (r == 0) return '0;
      if (r == 1) return 10'd1023;
      v = c + $urandom_range(0, 64) - 32;
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      return COORD_W'(v);
   endfunction

   task automatic send_item(logic [ACT_W-1:0] act, ect_pkg::coord_type px,
                            ect_pkg::coord_type py, logic [STAMP_W-1:0] stamp);
      int gap;
      req_valid  <= 1'b1;
      req_action <= act;
      req_pos_x  <= px;
      req_pos_y  <= py;
      req_stamp  <= stamp;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.note_item(act, px, py, stamp);
      gap = sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic add_near(int cx, int cy);
      send_item(ect_pkg::ACT_ADD, near_coord(cx), near_coord(cy), sb.origin + rel_now);
      rel_now += $urandom_range(0, 8);
   endtask

   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic idx, logic [DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.set_register(idx, value);
   endtask

   task automatic run_phase(logic [BW_W-1:0] w, logic [DATA_W-1:0] origin, bit squeeze);
      int n;
      int r;
      int len;
      int cx;
      int cy;
      wait_quiet();
      csr_write(ect_pkg::REG_BLEND, DATA_W'(w));
      csr_write(ect_pkg::REG_ORIGIN, origin);
      if (squeeze) begin
         hold_req = 1'b1;
      end
      n = 0;
      while (n < PHASE_ITEMS) begin
         r   = $urandom_range(0, 99);
         cx  = $urandom_range(0, 1023);
         cy  = $urandom_range(0, 1023);
         len = 1;
         if (r < 35) begin
            len = $urandom_range(1, 12);
            repeat (len) add_near(cx, cy);
         end else if (r < 45) begin
            // fill the store and run into the full case
            len = DEPTH - sb.held + $urandom_range(1, 6);
            repeat (len) add_near(cx, cy);
         end else if (r < 65) begin
            send_item(ect_pkg::ACT_FORGET, near_coord(cx), near_coord(cy),
                      rel_now - $urandom_range(0, 120));
         end else if (r < 78) begin
            send_item($urandom_range(0, 1) ? ect_pkg::ACT_MEASURE : ACT_SPARE,
                      near_coord(cx), near_coord(cy), $urandom);
         end else if (r < 90) begin
            send_item(ACT_W'($urandom_range(0, 3)), COORD_W'($urandom_range(0, 1023)),
                      COORD_W'($urandom_range(0, 1023)), $urandom);
         end else begin
            send_item(ect_pkg::ACT_FORGET, near_coord(cx), near_coord(cy),
                      $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000);
         end
         n += len;
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, reset register values
      send_item(ect_pkg::ACT_MEASURE, 10'd0, 10'd0, 32'h0000_0000);
      send_item(ect_pkg::ACT_FORGET, 10'd1023, 10'd1023, 32'h7FFF_FFFF);
      send_item(ect_pkg::ACT_ADD, 10'd0, 10'd0, 32'h8000_0000);
      send_item(ect_pkg::ACT_ADD, 10'd1023, 10'd1023, 32'h0000_0000);
      send_item(ect_pkg::ACT_ADD, 10'd1023, 10'd0, 32'h7FFF_FFFE);
      send_item(ect_pkg::ACT_ADD, 10'd0, 10'd1023, 32'h0000_0010);
      send_item(ect_pkg::ACT_MEASURE, 10'd512, 10'd512, 32'hFFFF_FFFF);
      send_item(ACT_SPARE, 10'd1023, 10'd0, 32'h5555_5555);
      send_item(ect_pkg::ACT_FORGET, 10'd0, 10'd0, 32'h8000_0000);
      send_item(ect_pkg::ACT_FORGET, 10'd100, 10'd200, 32'h0000_0000);
      send_item(ect_pkg::ACT_FORGET, 10'd0, 10'd0, 32'hFFFF_FFFF);
      send_item(ect_pkg::ACT_FORGET, 10'd1023, 10'd1023, 32'h7FFF_FFFF);
      // empty store keeps the old mean
      send_item(ect_pkg::ACT_MEASURE, 10'd1023, 10'd1023, 32'hAAAA_AAAA);
      send_item(ect_pkg::ACT_ADD, 10'd5, 10'd6, 32'h1234_5678);
      send_item(ect_pkg::ACT_ADD, 10'd1023, 10'd1023, 32'h1234_5679);
      send_item(ect_pkg::ACT_FORGET, 10'd0, 10'd0, 32'h7FFF_FFFF);

      rel_now = $urandom_range(0, 1000) - 500;
      run_phase(ect_pkg::W_ONE, 32'h0000_0000, 1'b0);
      run_phase(9'd0, 32'h8000_0000, 1'b1);
      run_phase(9'd511, 32'h7FFF_FFFF, 1'b0);
      run_phase(9'd1, $urandom, 1'b0);
      run_phase(9'd128, $urandom, 1'b0);
      run_phase(ect_pkg::BLEND_RESET, 32'hFFFF_FFFF, 1'b0);

      wait_quiet();
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
